// ----- hw/rtl/mna_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mna_pkg
// Shared types and constants of the MIDI note arpeggiator.
// ----------------------------------------------------------------------------
package mna_pkg;

   localparam logic [7:0] KIND_MASK     = 8'hF0;
   localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
   localparam logic [7:0] KIND_NOTE_OFF = 8'h80;

   localparam logic [2:0] MODE_UP_DOWN = 3'd0;
   localparam logic [2:0] MODE_UP      = 3'd1;
   localparam logic [2:0] MODE_DOWN    = 3'd2;
   localparam logic [2:0] MODE_RANDOM  = 3'd3;

   localparam logic [1:0] REG_ARP_MODE   = 2'd0;
   localparam logic [1:0] REG_PHASE_STEP = 2'd1;

   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   // floor(x / 100) is (x * 5242) >> 19, low by at most one for 16-bit x.
   localparam logic [12:0] RECIP_100 = 13'd5242;
   localparam int          RECIP_SHIFT = 19;

   // Rounded up, (x * 5243) >> 19 is exactly floor(x / 100) for x below 40000.
   localparam logic [12:0] RECIP_100_UP = 13'd5243;

   typedef struct packed {
      logic       load;     // copy the held entry into the sort slot
      logic       sort_en;  // one odd-even compare and exchange pass
      logic       phase;    // parity of the pairs compared in this pass
      logic       clr_en;   // clear every held entry equal to note
      logic [6:0] note;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/mna_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mna_cell
// One slot of the held-note row: keeps the held note and its slot of the
// sorted copy, and exchanges with its neighbors during odd-even sorting.
// ----------------------------------------------------------------------------
module mna_cell #(
   parameter int IDX = 0,
   parameter int N   = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mna_pkg::cell_ctrl_type ctrl,
   input  logic                  wr_en,
   input  logic [6:0]            left_val,
   input  logic [6:0]            right_val,
   output logic [6:0]            sort_val
);
   import mna_pkg::*;

   localparam logic PAR = 1'((IDX % 2));
   localparam bit HAS_RIGHT = (IDX < N - 1);
   localparam bit HAS_LEFT  = (IDX > 0);

   logic [6:0] held_ff, held_in;
   logic [6:0] sort_ff, sort_in;
   logic       lower, upper;

   always_comb begin
      lower = HAS_RIGHT && (ctrl.phase == PAR);
      upper = HAS_LEFT && (ctrl.phase != PAR);

      if (wr_en) begin
         held_in = ctrl.note;
      end else if (ctrl.clr_en && (held_ff == ctrl.note)) begin
         held_in = 7'd0;
      end else begin
         held_in = held_ff;
      end

      if (ctrl.load) begin
         sort_in = held_ff;
      end else if (ctrl.sort_en && lower) begin
         sort_in = (right_val < sort_ff) ? right_val : sort_ff;
      end else if (ctrl.sort_en && upper) begin
         sort_in = (left_val > sort_ff) ? left_val : sort_ff;
      end else begin
         sort_in = sort_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 7'd0;
         sort_ff <= 7'd0;
      end else begin
         held_ff <= held_in;
         sort_ff <= sort_in;
      end
   end

   assign sort_val = sort_ff;

endmodule

// ----- hw/rtl/midi_note_arpeggiator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_arpeggiator
// Holds up to MAX_NOTES notes from note-on/note-off messages, keeps a sorted
// copy in a row of cells, and steps through it at a phase-accumulator rate.
// ----------------------------------------------------------------------------
//  Channel   Dir   Payload
//  req_      in    tdata: status_byte[7:0], note_number[14:8], velocity[21:15]
//                  tuser: msg_valid
//  rsp_      out   tdata: note_out[6:0];  tuser: step_tick
//  csr_      in    index 0 arp_mode, index 1 phase_step
//
//  An item without a note change goes through S_STEP and S_FIN; a note change
//  first passes S_LOAD and the odd-even sort passes of S_SORT over the cell
//  row. Random mode adds S_RQ, S_RR, S_RP and S_RO. A pending result stalls
//  the next item only in its last state, S_FIN.
// ----------------------------------------------------------------------------
module midi_note_arpeggiator #(
   parameter int MAX_NOTES  = 10,
   parameter int PHASE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // status_byte, note_number, velocity
   input  logic        req_tuser,   // msg_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // note_out, zero pad
   output logic        rsp_tuser,   // step_tick
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   import mna_pkg::*;

   localparam int CW = $clog2(MAX_NOTES + 1);
   localparam int IW = $clog2(MAX_NOTES);
   localparam int PW = 7 + CW;
   localparam int SW = ((PHASE_BITS > 24) ? PHASE_BITS : 24) + 1;
   localparam int OW = PW + 13;
   localparam logic [CW-1:0] FULL = CW'(MAX_NOTES);
   localparam logic [CW-1:0] TOP  = CW'(MAX_NOTES - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOAD = 4'd1;
   localparam logic [3:0] S_SORT = 4'd2;
   localparam logic [3:0] S_STEP = 4'd3;
   localparam logic [3:0] S_RQ   = 4'd4;
   localparam logic [3:0] S_RR   = 4'd5;
   localparam logic [3:0] S_RP   = 4'd6;
   localparam logic [3:0] S_RO   = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [2:0]            mode_ff;
   logic [23:0]           pstep_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  up_ff, up_in;
   logic [PHASE_BITS-1:0] acc_ff, acc_in;
   logic                  first_ff, first_in;
   logic [15:0]           lfsr_ff, lfsr_in;
   logic                  tick_ff, tick_in;
   logic [6:0]            note_ff, note_in;
   logic [CW-1:0]         pass_ff, pass_in;
   logic [9:0]            q_ff, q_in;
   logic [6:0]            r_ff, r_in;
   logic [PW-1:0]         p_ff, p_in;
   logic                  rv_ff, rv_in;
   logic                  rtick_ff, rtick_in;
   logic [6:0]            rnote_ff, rnote_in;

   cell_ctrl_type         ctrl;
   logic [MAX_NOTES-1:0]  wr_vec;
   logic [6:0]            sort_q [MAX_NOTES];

   logic [7:0]            kind;
   logic [6:0]            in_note, in_vel;
   logic                  take, is_on, is_off;
   logic [CW-1:0]         low, nxt;
   logic [SW-1:0]         sum;
   logic                  fire;
   logic [28:0]           q_prod;
   logic [16:0]           rem;
   logic [OW-1:0]         o_prod;
   logic [CW:0]           offs;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign take       = req_tvalid && req_tready;
   assign kind       = req_tdata[7:0] & KIND_MASK;
   assign in_note    = req_tdata[14:8];
   assign in_vel     = req_tdata[21:15];
   assign is_on      = req_tuser && (kind == KIND_NOTE_ON) && (in_vel != 7'd0);
   assign is_off     = req_tuser && !is_on &&
                       ((kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON));
   assign low        = FULL - count_ff;

   genvar g;
   generate
      for (g = 0; g < MAX_NOTES; g++) begin : g_cell
         logic [6:0] lv, rv;
         assign wr_vec[g] = take && is_on && (count_ff < FULL) && (count_ff == CW'(g));
         if (g > 0) begin : g_l
            assign lv = sort_q[g-1];
         end else begin : g_l0
            assign lv = 7'd0;
         end
         if (g < MAX_NOTES - 1) begin : g_r
            assign rv = sort_q[g+1];
         end else begin : g_r0
            assign rv = 7'd0;
         end
         mna_cell #(.IDX(g), .N(MAX_NOTES)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .wr_en     (wr_vec[g]),
            .left_val  (lv),
            .right_val (rv),
            .sort_val  (sort_q[g])
         );
      end
   endgenerate

   always_comb begin
      ctrl.load    = (state_ff == S_LOAD);
      ctrl.sort_en = (state_ff == S_SORT);
      ctrl.phase   = pass_ff[0];
      ctrl.clr_en  = take && is_off;
      ctrl.note    = in_note;

      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      up_in    = up_ff;
      acc_in   = acc_ff;
      first_in = first_ff;
      lfsr_in  = lfsr_ff;
      tick_in  = tick_ff;
      note_in  = note_ff;
      pass_in  = pass_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      p_in     = p_ff;
      rv_in    = rv_ff && !rsp_tready;
      rtick_in = rtick_ff;
      rnote_in = rnote_ff;
      nxt      = '0;
      fire     = 1'b0;

      sum    = SW'(acc_ff) + SW'(pstep_ff);
      q_prod = 29'(lfsr_ff) * 29'(RECIP_100);
      rem    = 17'(lfsr_ff) - 17'(q_ff) * 17'd100;
      o_prod = OW'(p_ff) * OW'(RECIP_100_UP);
      offs   = o_prod[OW-1:RECIP_SHIFT];

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (is_on && (count_ff < FULL)) begin
                  count_in = count_ff + 1'b1;
                  state_in = S_LOAD;
               end else if (is_off) begin
                  if (count_ff != '0) count_in = count_ff - 1'b1;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_LOAD: begin
            pass_in  = '0;
            state_in = S_SORT;
         end
         S_SORT: begin
            pass_in = pass_ff + 1'b1;
            if (pass_ff == TOP) state_in = S_STEP;
         end
         S_STEP: begin
            state_in = S_FIN;
            if (count_ff != '0) begin
               if ((acc_ff == '0) && first_ff) begin
                  fire = 1'b1;
               end else begin
                  acc_in = sum[PHASE_BITS-1:0];
                  fire   = (sum >= (SW'(1) << PHASE_BITS));
               end
               if (fire) first_in = 1'b0;
               tick_in = fire;
               if (fire) begin
                  if (sort_q[idx_ff] != 7'd0) note_in = sort_q[idx_ff];
                  unique case (mode_ff)
                     MODE_UP_DOWN: begin
                        if (up_ff) begin
                           nxt = (CW'(idx_ff) < TOP) ? CW'(idx_ff) + 1'b1 : low;
                           if (nxt == TOP) up_in = 1'b0;
                        end else begin
                           nxt = (CW'(idx_ff) > low) ? CW'(idx_ff) - 1'b1 : TOP;
                           if (nxt == low) up_in = 1'b1;
                        end
                        idx_in = nxt[IW-1:0];
                     end
                     MODE_UP: begin
                        nxt    = (CW'(idx_ff) < TOP) ? CW'(idx_ff) + 1'b1 : low;
                        idx_in = nxt[IW-1:0];
                     end
                     MODE_DOWN: begin
                        nxt    = (CW'(idx_ff) > low) ? CW'(idx_ff) - 1'b1 : TOP;
                        idx_in = nxt[IW-1:0];
                     end
                     MODE_RANDOM: begin
                        lfsr_in  = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
                        state_in = S_RQ;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_RQ: begin
            q_in     = q_prod[28:RECIP_SHIFT];
            state_in = S_RR;
         end
         S_RR: begin
            r_in     = (rem >= 17'd100) ? 7'(rem - 17'd100) : 7'(rem);
            state_in = S_RP;
         end
         S_RP: begin
            p_in     = PW'(r_ff) * PW'(count_ff);
            state_in = S_RO;
         end
         S_RO: begin
            idx_in   = IW'((CW + 1)'(TOP) - offs);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               rtick_in = tick_ff;
               rnote_in = note_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= 3'd0;
         pstep_ff <= 24'd0;
         count_ff <= '0;
         idx_ff   <= IW'(MAX_NOTES - 1);
         up_ff    <= 1'b1;
         acc_ff   <= '0;
         first_ff <= 1'b1;
         lfsr_ff  <= LFSR_SEED;
         tick_ff  <= 1'b0;
         note_ff  <= 7'd0;
         pass_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         up_ff    <= up_in;
         acc_ff   <= acc_in;
         first_ff <= first_in;
         lfsr_ff  <= lfsr_in;
         tick_ff  <= tick_in;
         note_ff  <= note_in;
         pass_ff  <= pass_in;
         rv_ff    <= rv_in;
         if (csr_valid && (csr_index == REG_ARP_MODE)) mode_ff <= csr_data[2:0];
         if (csr_valid && (csr_index == REG_PHASE_STEP)) pstep_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      r_ff     <= r_in;
      p_ff     <= p_in;
      rtick_ff <= rtick_in;
      rnote_ff <= rnote_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rtick_ff;
   assign rsp_tdata  = {1'b0, rnote_ff};

endmodule
